// ===== design/glu_pkg.sv =====
// shared types for the gcd and lcm unit
`default_nettype none

package glu_pkg;

    // input tdata layout
    localparam int unsigned IN_FIELD_W  = 32;
    localparam int unsigned IN_DATA_W   = 64;
    // output tdata layout
    localparam int unsigned DIV_FIELD_W = 32;
    localparam int unsigned MUL_FIELD_W = 64;
    localparam int unsigned OUT_DATA_W  = 96;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== design/gcd_lcm_unit.sv =====
// top level: greatest common divisor and least common multiple of two operands
//
//  channel   dir  fields (low bit up)
//  s_axis    in   operand_a [31:0], operand_b [63:32]
//  m_axis    out  divisor [31:0], multiple [95:32]
//
// one item at a time; each euclid remainder step runs the serial divider,
// then the divider forms a/divisor and a shift-add multiply forms the
// multiple, with a final state that loads the result register.
// the divider's one bit per cycle loop dominates the run time.
// reset clears control state only; a waiting result holds until taken and the
// next item is accepted meanwhile.
`default_nettype none

module gcd_lcm_unit #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // operand_a, operand_b
    input  wire logic [glu_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // divisor, multiple
    output logic [glu_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned CW = $clog2(W);
    localparam logic [CW-1:0] LAST = CW'(W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EUC,
        S_EUCW,
        S_QUOT,
        S_MUL,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [W-1:0]    r_a;
    logic [W-1:0]    r_b;
    logic [W-1:0]    r_a0;
    logic [W-1:0]    r_b0;
    logic [2*W-1:0]  r_prod;
    logic [CW-1:0]   r_cnt;
    logic            r_out_valid;
    logic [glu_pkg::DIV_FIELD_W-1:0] r_out_div;
    logic [glu_pkg::MUL_FIELD_W-1:0] r_out_mul;

    logic               w_accept;
    logic               w_start;
    logic [W-1:0]       w_dividend;
    logic [W-1:0]       w_divisor;
    logic [W-1:0]       w_quo;
    logic [W-1:0]       w_rem;
    glu_pkg::t_div_stat w_div;
    logic [W:0]         w_sum;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // remainder step while b is nonzero, else a/divisor
    assign w_dividend = (r_b != '0) ? r_a : r_a0;
    assign w_divisor  = (r_b != '0) ? r_b : r_a;
    assign w_start    = (r_state == S_EUC) && !w_div.busy
                        && ((r_b != '0) || (r_a != '0));

    glu_serdiv #(
        .OPERAND_WIDTH(W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_remainder(w_rem),
        .o_stat     (w_div)
    );

    assign w_sum = {1'b0, r_prod[2*W-1:W]} + (r_prod[0] ? {1'b0, r_b0} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_a     <= i_s_axis_tdata[W-1:0];
                        r_b     <= i_s_axis_tdata[glu_pkg::IN_FIELD_W +: W];
                        r_a0    <= i_s_axis_tdata[W-1:0];
                        r_b0    <= i_s_axis_tdata[glu_pkg::IN_FIELD_W +: W];
                        r_state <= S_EUC;
                    end
                end
                S_EUC: begin
                    if (r_b != '0) begin
                        if (w_start) begin
                            r_state <= S_EUCW;
                        end
                    end else if (r_a == '0) begin
                        r_prod  <= '0;
                        r_state <= S_DONE;
                    end else if (w_start) begin
                        r_state <= S_QUOT;
                    end
                end
                S_EUCW: begin
                    if (w_div.done) begin
                        r_a     <= r_b;
                        r_b     <= w_rem;
                        r_state <= S_EUC;
                    end
                end
                S_QUOT: begin
                    if (w_div.done) begin
                        r_prod  <= {{W{1'b0}}, w_quo};
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= {w_sum, r_prod[W-1:1]};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_div   <= glu_pkg::DIV_FIELD_W'(r_a);
                        r_out_mul   <= glu_pkg::MUL_FIELD_W'(r_prod);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_mul, r_out_div};

endmodule

`default_nettype wire

// ===== design/glu_serdiv.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module glu_serdiv #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [OPERAND_WIDTH-1:0] i_dividend,
    input  wire logic [OPERAND_WIDTH-1:0] i_divisor,
    output logic [OPERAND_WIDTH-1:0]      o_quotient,
    output logic [OPERAND_WIDTH-1:0]      o_remainder,
    output glu_pkg::t_div_stat            o_stat
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned CW = $clog2(W);
    localparam logic [CW-1:0] LAST = CW'(W - 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;

    logic [W:0]    w_trial;
    logic [W:0]    w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = ~w_diff[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
            r_quo <= {r_quo[W-2:0], w_ge};
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ===== dv/tb_gcd_lcm_unit.sv =====
`timescale 1ns / 100ps
// self-checking bench for the gcd and lcm unit: directed and random operand pairs under stalls

module tb_gcd_lcm_unit;

    localparam int unsigned OPW        = 32;
    localparam int unsigned IDLE_LIMIT = 20000;
    localparam int unsigned DRAIN_WAIT = 2000;
    localparam int unsigned PHASE_ITEMS = 300;

    typedef struct packed {
        logic [31:0] divisor;
        logic [63:0] multiple;
    } t_gcd_lcm;

    class gcd_scoreboard;
        t_gcd_lcm    pending[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned zero_cases;

        function t_gcd_lcm gcd_lcm_of(logic [31:0] a_in, logic [31:0] b_in);
            logic [31:0] x;
            logic [31:0] y;
            logic [31:0] r;
            logic [63:0] mask;
            t_gcd_lcm    res;
            mask = (64'd1 << OPW) - 64'd1;
            x = a_in & mask[31:0];
            y = b_in & mask[31:0];
            res.multiple = 64'd0;
            if (x == 0 || y == 0)
                zero_cases++;
            while (y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            res.divisor = x;
            if (x != 0)
                res.multiple = 64'((a_in & mask[31:0]) / x) * 64'(b_in & mask[31:0]);
            return res;
        endfunction

        function void note_operands(logic [63:0] data);
            pending.push_back(gcd_lcm_of(data[31:0], data[63:32]));
        endfunction

        function void check_result(logic [95:0] data);
            t_gcd_lcm want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, divisor %0d multiple %0d",
                         $time, data[31:0], data[95:32]);
                return;
            end
            want = pending.pop_front();
            if (data[31:0] !== want.divisor) begin
                mismatches++;
                $display("%0t: divisor mismatch, expected %0d actual %0d",
                         $time, want.divisor, data[31:0]);
            end
            if (data[95:32] !== want.multiple) begin
                mismatches++;
                $display("%0t: multiple mismatch, expected %0d actual %0d",
                         $time, want.multiple, data[95:32]);
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_valid = 1'b0;
    logic [glu_pkg::IN_DATA_W-1:0]  s_data = '0;
    logic                           m_ready = 1'b0;
    logic                           s_ready;
    logic                           m_valid;
    logic [glu_pkg::OUT_DATA_W-1:0] m_data;

    int unsigned   send_idle_pct = 0;
    int unsigned   recv_stall_pct = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   items_sent = 0;
    gcd_scoreboard sb;

    gcd_lcm_unit #(
        .OPERAND_WIDTH (OPW)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // item monitor and watchdog, sampling the values present at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_ready)
                sb.note_operands(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_pair(logic [31:0] a, logic [31:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {b, a};
        do
            @(posedge i_clk);
        while (!s_ready);
        items_sent++;
    endtask

    task automatic send_random_pair();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] g;
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            a = $urandom;
            b = $urandom;
        end else if (kind < 55) begin
            g = $urandom_range(1, 65535);
            a = g * $urandom_range(0, 65535);
            b = g * $urandom_range(0, 65535);
        end else if (kind < 70) begin
            a = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
        end else if (kind < 80) begin
            a = $urandom_range(1, 1 << 20);
            b = a * $urandom_range(1, 4095);
            if ($urandom_range(0, 1) == 1) begin
                g = a;
                a = b;
                b = g;
            end
        end else if (kind < 85) begin
            a = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
            b = 32'd0;
            if ($urandom_range(0, 1) == 1) begin
                b = a;
                a = 32'd0;
            end
        end else if (kind < 92) begin
            a = 32'($urandom_range(1, 255)) << $urandom_range(0, 24);
            b = 32'($urandom_range(1, 255)) << $urandom_range(0, 24);
        end else begin
            a = $urandom;
            b = a + $urandom_range(0, 2);
        end
        send_pair(a, b);
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero operands, extremes, worst-case euclid chain and large coprimes
        send_pair(32'd0, 32'd0);
        send_pair(32'd0, 32'd12345);
        send_pair(32'hFFFF_FFFF, 32'd0);
        send_pair(32'd1, 32'd1);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'd1);
        send_pair(32'd1, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_pair(32'd2971215073, 32'd1836311903);
        send_pair(32'd1836311903, 32'd2971215073);
        send_pair(32'd4294967291, 32'd4294967279);
        send_pair(32'h8000_0000, 32'h0001_0000);
        send_pair(32'h0001_0000, 32'h8000_0000);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555);
        send_pair(32'h5555_5555, 32'hAAAA_AAAA);
        send_pair(32'd12, 32'd18);
        send_pair(32'd7, 32'd13);
        send_pair(32'd65536, 32'd65535);
        send_pair(32'd1000000, 32'd999999);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 47;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 47;
                end
                default: begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            repeat (PHASE_ITEMS) send_random_pair();
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d operand pairs sent, %0d results checked, %0d with a zero operand",
                 items_sent, sb.checked, sb.zero_cases);
        $display("stall phases: none, sender gaps, receiver back-pressure, both; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
